// File: src/cms_pkg.sv
// ----------------------------------------------------------------------------
// cms_pkg
// Shared sizes, register indexes and control types of the count-min sketch
// with configurable row sizes.
// ----------------------------------------------------------------------------
package cms_pkg;

  // sketch geometry
  localparam int unsigned ROWS         = 4;
  localparam int unsigned ROW_DEPTH    = 4096;
  localparam int unsigned COUNTER_BITS = 8;

  // fixed field widths
  localparam int unsigned ELEM_W     = 64;
  localparam int unsigned ROW_SIZE_W = 13;
  localparam int unsigned OCC_W      = 13;
  localparam int unsigned MIN_W      = 8;
  localparam int unsigned NUM_CFG    = 4;
  localparam int unsigned CFG_IDX_W  = 2;

  // derived widths
  localparam int unsigned ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned BKT_W  = $clog2(ROW_DEPTH);
  localparam int unsigned ADDR_W = ROW_W + BKT_W;
  localparam int unsigned DEPTH_W = $clog2(ROW_DEPTH + 1);
  localparam int unsigned MOD_W  = (DEPTH_W > ROW_SIZE_W) ? DEPTH_W : ROW_SIZE_W;

  // remainder unit consumes one byte of the element per cycle
  localparam int unsigned DIGIT_W    = 8;
  localparam int unsigned NUM_DIGITS = ELEM_W / DIGIT_W;
  localparam int unsigned CNT_W      = $clog2(NUM_DIGITS);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_SIZE_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_SIZE_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_SIZE_C = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_SIZE_D = 2'd3;

  // row sizes after reset
  localparam logic [ROW_SIZE_W-1:0] ROW_SIZE_RESET [NUM_CFG] =
    '{13'd4093, 13'd4091, 13'd4079, 13'd4073};

  // control of the remainder unit
  typedef struct packed {
    logic clr;
    logic en;
  } mod_ctrl_t;

endpackage

// File: src/cms_mod_unit.sv
// ----------------------------------------------------------------------------
// cms_mod_unit
// Iterative remainder of a long key by a row size: restoring reduction of
// one byte of the key per cycle, most significant byte first.
// ----------------------------------------------------------------------------
module cms_mod_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cms_pkg::mod_ctrl_t              ctrl_i,
  input  logic [cms_pkg::DIGIT_W-1:0]     digit_i,
  input  logic [cms_pkg::MOD_W-1:0]       size_i,
  output logic [cms_pkg::MOD_W-1:0]       rem_o
);

  logic [cms_pkg::MOD_W-1:0] rem_q;
  logic [cms_pkg::MOD_W-1:0] rem_d;

  // eight shift and conditional subtract steps on the running remainder
  always_comb begin
    logic [cms_pkg::MOD_W-1:0] acc;
    logic [cms_pkg::MOD_W:0]   trial;
    acc = rem_q;
    for (int i = 0; i < cms_pkg::DIGIT_W; i++) begin
      trial = {acc, digit_i[cms_pkg::DIGIT_W-1-i]};
      if (trial >= {1'b0, size_i}) begin
        trial = trial - {1'b0, size_i};
      end
      acc = trial[cms_pkg::MOD_W-1:0];
    end
    rem_d = acc;
  end

  // remainder register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (ctrl_i.clr) begin
      rem_q <= '0;
    end else if (ctrl_i.en) begin
      rem_q <= rem_d;
    end
  end

  assign rem_o = rem_q;

endmodule

// File: src/count_min_sketch_prime_rows_top.sv
// ----------------------------------------------------------------------------
// count_min_sketch_prime_rows_top
// Count-min sketch over four rows of saturating counters with configurable
// row sizes, one shared remainder unit and one counter memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries func_i and element_i.
//   An insert (func 0) bumps the selected counter of every row and gives no
//   result; a query (func 1) gives one transfer on the output channel
//   (out_valid_o / out_ready_i) with the row minimum and occupancy counts.
//   Each item works through the rows in turn: per row, the remainder unit
//   reduces the key (one key byte per cycle), then one memory read and one
//   update on the single counter memory port. in_ready_o rises again after
//   the update of the last row, so the block takes no new item before it is
//   through with the last one; a query result goes to the output register there.
//   After reset the counter memory is zeroed by a clearing pass over all 16384
//   entries, one entry per cycle; in_ready_o stays low meanwhile, while the
//   row size registers can be written at any time through cfg_we_i.
//   A result waiting in the output register does not block new items; only a
//   following query waits in its last cycle until the output is taken.
// ----------------------------------------------------------------------------
module count_min_sketch_prime_rows_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cms_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [cms_pkg::ROW_SIZE_W-1:0]    cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              func_i,
  input  logic [cms_pkg::ELEM_W-1:0]        element_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [cms_pkg::MIN_W-1:0]         min_count_o,
  output logic [cms_pkg::OCC_W-1:0]         occupied_a_o,
  output logic [cms_pkg::OCC_W-1:0]         occupied_b_o,
  output logic [cms_pkg::OCC_W-1:0]         occupied_c_o,
  output logic [cms_pkg::OCC_W-1:0]         occupied_d_o
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MOD   = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_UPD   = 3'd4;

  localparam int unsigned CntW   = cms_pkg::COUNTER_BITS;
  localparam int unsigned MinMax = (2 ** cms_pkg::MIN_W) - 1;

  // control state
  logic [2:0]                        state_q, state_d;
  logic [cms_pkg::ROW_SIZE_W-1:0]    cfg_q [cms_pkg::NUM_CFG];
  logic [cms_pkg::ROW_SIZE_W-1:0]    cfg_d [cms_pkg::NUM_CFG];
  logic [cms_pkg::ADDR_W-1:0]        clr_addr_q, clr_addr_d;
  logic                              out_valid_q, out_valid_d;
  logic [cms_pkg::OCC_W-1:0]         occ_q [cms_pkg::ROWS];
  logic [cms_pkg::OCC_W-1:0]         occ_d [cms_pkg::ROWS];

  // item payload and sequencing
  logic                              func_q, func_d;
  logic [cms_pkg::ELEM_W-1:0]        elem_q, elem_d;
  logic [cms_pkg::ROW_W-1:0]         row_q, row_d;
  logic [cms_pkg::CNT_W-1:0]         cnt_q, cnt_d;
  logic [CntW-1:0]                   min_q, min_d;
  logic                              zero_q, zero_d;
  logic [cms_pkg::MIN_W-1:0]         out_min_q, out_min_d;
  logic [cms_pkg::OCC_W-1:0]         out_occ_q [cms_pkg::NUM_CFG];
  logic [cms_pkg::OCC_W-1:0]         out_occ_d [cms_pkg::NUM_CFG];

  // counter memory
  logic [CntW-1:0]                   mem_q [2 ** cms_pkg::ADDR_W];
  logic [CntW-1:0]                   rd_q;
  logic                              mem_we;
  logic                              mem_re;
  logic [cms_pkg::ADDR_W-1:0]        mem_waddr;
  logic [CntW-1:0]                   mem_wdata;

  // datapath
  cms_pkg::mod_ctrl_t                mod_ctrl;
  logic [cms_pkg::MOD_W-1:0]         row_size;
  logic [cms_pkg::MOD_W-1:0]         size_raw;
  logic [cms_pkg::MOD_W-1:0]         mod_rem;
  logic [cms_pkg::DIGIT_W-1:0]       digit;
  logic [cms_pkg::ADDR_W-1:0]        rmw_addr;
  logic                              last_row;
  logic                              cnt_zero;
  logic                              cnt_max;
  logic [CntW-1:0]                   fmin;
  logic                              fzero;
  logic [cms_pkg::MIN_W-1:0]         sat_min;

  // size of the current row, zero read as one and clamped to the row depth
  always_comb begin
    size_raw = cms_pkg::MOD_W'(cms_pkg::ROW_DEPTH);
    for (int r = 0; r < cms_pkg::NUM_CFG; r++) begin
      if (r < cms_pkg::ROWS && row_q == cms_pkg::ROW_W'(r)) begin
        size_raw = cms_pkg::MOD_W'(cfg_q[r]);
      end
    end
    if (size_raw == '0) begin
      row_size = cms_pkg::MOD_W'(1);
    end else if (size_raw > cms_pkg::MOD_W'(cms_pkg::ROW_DEPTH)) begin
      row_size = cms_pkg::MOD_W'(cms_pkg::ROW_DEPTH);
    end else begin
      row_size = size_raw;
    end
  end

  // key byte for the remainder unit, most significant first
  assign digit = elem_q[cnt_q * cms_pkg::DIGIT_W +: cms_pkg::DIGIT_W];

  cms_mod_unit u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mod_ctrl),
    .digit_i (digit),
    .size_i  (row_size),
    .rem_o   (mod_rem)
  );

  // bucket address and counter evaluation
  assign rmw_addr = {row_q, mod_rem[cms_pkg::BKT_W-1:0]};
  assign last_row = (row_q == cms_pkg::ROW_W'(cms_pkg::ROWS - 1));
  assign cnt_zero = (rd_q == '0);
  assign cnt_max  = &rd_q;
  assign fmin     = (row_q == '0 || rd_q < min_q) ? rd_q : min_q;
  assign fzero    = zero_q | cnt_zero;

  always_comb begin
    if (fzero) begin
      sat_min = '0;
    end else if (32'(fmin) > 32'(MinMax)) begin
      sat_min = '1;
    end else begin
      sat_min = cms_pkg::MIN_W'(fmin);
    end
  end

  // configuration writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cms_pkg::REG_ROW_SIZE_A: cfg_d[0] = cfg_wdata_i;
        cms_pkg::REG_ROW_SIZE_B: cfg_d[1] = cfg_wdata_i;
        cms_pkg::REG_ROW_SIZE_C: cfg_d[2] = cfg_wdata_i;
        cms_pkg::REG_ROW_SIZE_D: cfg_d[3] = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // sequencer: clear pass, then per row remainder, read, update
  always_comb begin
    state_d     = state_q;
    clr_addr_d  = clr_addr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    occ_d       = occ_q;
    func_d      = func_q;
    elem_d      = elem_q;
    row_d       = row_q;
    cnt_d       = cnt_q;
    min_d       = min_q;
    zero_d      = zero_q;
    out_min_d   = out_min_q;
    out_occ_d   = out_occ_q;
    mod_ctrl    = '0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = rmw_addr;
    mem_wdata   = rd_q + CntW'(1);

    unique case (state_q)
      ST_CLEAR: begin
        mem_we     = 1'b1;
        mem_waddr  = clr_addr_q;
        mem_wdata  = '0;
        clr_addr_d = clr_addr_q + cms_pkg::ADDR_W'(1);
        if (&clr_addr_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          func_d       = func_i;
          elem_d       = element_i;
          row_d        = '0;
          cnt_d        = cms_pkg::CNT_W'(cms_pkg::NUM_DIGITS - 1);
          zero_d       = 1'b0;
          mod_ctrl.clr = 1'b1;
          state_d      = ST_MOD;
        end
      end
      ST_MOD: begin
        mod_ctrl.en = 1'b1;
        cnt_d       = cnt_q - cms_pkg::CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        mem_re  = 1'b1;
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (!func_q) begin
          // insert: occupancy on first hit, saturating counter bump
          if (cnt_zero && !(&occ_q[row_q])) begin
            occ_d[row_q] = occ_q[row_q] + cms_pkg::OCC_W'(1);
          end
          mem_we = !cnt_max;
        end else begin
          min_d  = fmin;
          zero_d = fzero;
        end
        if (!last_row) begin
          row_d        = row_q + cms_pkg::ROW_W'(1);
          cnt_d        = cms_pkg::CNT_W'(cms_pkg::NUM_DIGITS - 1);
          mod_ctrl.clr = 1'b1;
          state_d      = ST_MOD;
        end else if (!func_q) begin
          state_d = ST_IDLE;
        end else if (!out_valid_q || out_ready_i) begin
          // query result into the output register
          out_valid_d = 1'b1;
          out_min_d   = sat_min;
          for (int j = 0; j < cms_pkg::NUM_CFG; j++) begin
            out_occ_d[j] = (j < cms_pkg::ROWS) ? occ_q[j % cms_pkg::ROWS] : '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cfg_q       <= cms_pkg::ROW_SIZE_RESET;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
      for (int r = 0; r < cms_pkg::ROWS; r++) begin
        occ_q[r] <= '0;
      end
    end else begin
      state_q     <= state_d;
      cfg_q       <= cfg_d;
      clr_addr_q  <= clr_addr_d;
      out_valid_q <= out_valid_d;
      occ_q       <= occ_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    func_q    <= func_d;
    elem_q    <= elem_d;
    row_q     <= row_d;
    cnt_q     <= cnt_d;
    min_q     <= min_d;
    zero_q    <= zero_d;
    out_min_q <= out_min_d;
    out_occ_q <= out_occ_d;
  end

  // counter memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem_q[rmw_addr];
    end
  end

  // outputs
  assign in_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign min_count_o  = out_min_q;
  assign occupied_a_o = out_occ_q[0];
  assign occupied_b_o = out_occ_q[1];
  assign occupied_c_o = out_occ_q[2];
  assign occupied_d_o = out_occ_q[3];

  // an accepted item starts with the remainder of row 0
  a_accept_starts_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_MOD && row_q == '0))
    else $error("accepted item did not start the remainder sequence");

  // the finished remainder always addresses a bucket inside the row
  a_bucket_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> (mod_rem < row_size))
    else $error("bucket outside the row size");

  // only a query raises a result
  a_result_from_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(func_q))
    else $error("result raised by an insert");

  // occupancy of row 0 never goes down
  a_occ_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_CLEAR) |=> (occ_q[0] >= $past(occ_q[0])))
    else $error("row occupancy decreased");

endmodule
